// ===== design/tgrcc_pkg.sv =====
`default_nettype none
package tgrcc_pkg;

  localparam logic [7:0]  SEP_CHAR    = 8'h26;
  localparam logic [2:0]  HEX_LEN     = 3'd4;
  localparam logic [2:0]  TAIL_LEN    = 3'd5;
  localparam logic [2:0]  TAIL_SAT    = 3'd6;
  localparam logic [16:0] CHECK_TOTAL = 17'h10000;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_NO_SEP   = 2'd1;
  localparam logic [1:0] ERR_TAIL_LEN = 2'd2;
  localparam logic [1:0] ERR_CHECKSUM = 2'd3;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        check_passed;
    logic [1:0]  error_code;
    logic [15:0] computed_sum;
    logic [15:0] received_checksum;
  } out_item_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] digit;
  } hex_digit_t;

  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t r;
    r.is_hex = 1'b0;
    r.digit  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.is_hex = 1'b1;
      r.digit  = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.is_hex = 1'b1;
      r.digit  = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.is_hex = 1'b1;
      r.digit  = 4'(c - 8'h57);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/tank_gauge_reply_checksum_checker.sv =====
// The result of a reply is registered and appears in the cycle after its final byte transfer.
// Throughput: one byte per cycle; the byte state update and the result check are
// single-pass logic feeding the state registers and the result register.
// A final byte is held off only while an earlier result is still stalled at the output.
// Reset (rst_n low, synchronous) clears all reply state and empties the result register.
`default_nettype none
module tank_gauge_reply_checksum_checker (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  tgrcc_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output tgrcc_pkg::out_item_t  out_data
);

  logic [15:0] running_sum_r, running_sum_nxt;
  logic [15:0] sum_at_sep_r, sum_at_sep_nxt;
  logic        prev_amp_r, prev_amp_nxt;
  logic        sep_seen_r, sep_seen_nxt;
  logic [2:0]  tail_count_r, tail_count_nxt;
  logic [15:0] hex_acc_r, hex_acc_nxt;
  logic        hex_stop_r, hex_stop_nxt;
  logic        text_ended_r, text_ended_nxt;
  logic        out_valid_r;
  tgrcc_pkg::out_item_t out_data_r, result;
  tgrcc_pkg::hex_digit_t hd;
  logic        in_fire;
  logic        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = in_data.last_byte && !out_free;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign hd        = tgrcc_pkg::hex_value(in_data.reply_byte);

  always_comb begin
    running_sum_nxt = running_sum_r;
    sum_at_sep_nxt  = sum_at_sep_r;
    prev_amp_nxt    = prev_amp_r;
    sep_seen_nxt    = sep_seen_r;
    tail_count_nxt  = tail_count_r;
    hex_acc_nxt     = hex_acc_r;
    hex_stop_nxt    = hex_stop_r;
    text_ended_nxt  = text_ended_r;
    if (!text_ended_r) begin
      if (in_data.reply_byte == 8'd0) begin
        text_ended_nxt = 1'b1;
      end else if (!sep_seen_r) begin
        running_sum_nxt = running_sum_r + {8'd0, in_data.reply_byte};
        if (in_data.reply_byte == tgrcc_pkg::SEP_CHAR && prev_amp_r) begin
          sep_seen_nxt   = 1'b1;
          sum_at_sep_nxt = running_sum_nxt;
        end
        prev_amp_nxt = (in_data.reply_byte == tgrcc_pkg::SEP_CHAR);
      end else begin
        if (tail_count_r < tgrcc_pkg::HEX_LEN && !hex_stop_r) begin
          if (hd.is_hex) begin
            hex_acc_nxt = {hex_acc_r[11:0], hd.digit};
          end else begin
            hex_stop_nxt = 1'b1;
          end
        end
        if (tail_count_r < tgrcc_pkg::TAIL_SAT) begin
          tail_count_nxt = tail_count_r + 3'd1;
        end
      end
    end
  end

  always_comb begin
    result.computed_sum      = 16'd0;
    result.received_checksum = 16'd0;
    if (!sep_seen_nxt) begin
      result.error_code = tgrcc_pkg::ERR_NO_SEP;
    end else begin
      result.computed_sum      = sum_at_sep_nxt;
      result.received_checksum = hex_acc_nxt;
      if (tail_count_nxt != tgrcc_pkg::TAIL_LEN) begin
        result.error_code = tgrcc_pkg::ERR_TAIL_LEN;
      end else if (({1'b0, sum_at_sep_nxt} + {1'b0, hex_acc_nxt}) != tgrcc_pkg::CHECK_TOTAL) begin
        result.error_code = tgrcc_pkg::ERR_CHECKSUM;
      end else begin
        result.error_code = tgrcc_pkg::ERR_OK;
      end
    end
    result.check_passed = (result.error_code == tgrcc_pkg::ERR_OK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r <= 16'd0;
      sum_at_sep_r  <= 16'd0;
      prev_amp_r    <= 1'b0;
      sep_seen_r    <= 1'b0;
      tail_count_r  <= 3'd0;
      hex_acc_r     <= 16'd0;
      hex_stop_r    <= 1'b0;
      text_ended_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= in_fire && in_data.last_byte;
      end
      if (in_fire) begin
        if (in_data.last_byte) begin
          running_sum_r <= 16'd0;
          sum_at_sep_r  <= 16'd0;
          prev_amp_r    <= 1'b0;
          sep_seen_r    <= 1'b0;
          tail_count_r  <= 3'd0;
          hex_acc_r     <= 16'd0;
          hex_stop_r    <= 1'b0;
          text_ended_r  <= 1'b0;
        end else begin
          running_sum_r <= running_sum_nxt;
          sum_at_sep_r  <= sum_at_sep_nxt;
          prev_amp_r    <= prev_amp_nxt;
          sep_seen_r    <= sep_seen_nxt;
          tail_count_r  <= tail_count_nxt;
          hex_acc_r     <= hex_acc_nxt;
          hex_stop_r    <= hex_stop_nxt;
          text_ended_r  <= text_ended_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.last_byte) begin
      out_data_r <= result;
    end
  end

  a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_byte |=> out_valid_r)
    else $error("final byte transfer produced no result");

  a_final_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_byte |=> !sep_seen_r && running_sum_r == 16'd0
      && tail_count_r == 3'd0 && !text_ended_r)
    else $error("reply state not cleared after final byte");

  a_pass_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.check_passed == (out_data_r.error_code == tgrcc_pkg::ERR_OK))
    else $error("pass flag disagrees with error code");

  a_tail_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    tail_count_r <= tgrcc_pkg::TAIL_SAT)
    else $error("tail count beyond saturation");

  a_tail_needs_sep: assert property (@(posedge clk) disable iff (!rst_n)
    !sep_seen_r |-> tail_count_r == 3'd0 && sum_at_sep_r == 16'd0 && hex_acc_r == 16'd0)
    else $error("tail state changed before separator");

endmodule
`default_nettype wire

// ===== tb/sv/tb_tank_gauge_reply_checksum_checker.sv =====
`default_nettype none
module tb_tank_gauge_reply_checksum_checker;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]           b;
    logic                 lst;
    logic                 pinned;
    tgrcc_pkg::out_item_t want;
  } gauge_row_t;

  localparam int ITEM_TARGET = 1850;

  localparam gauge_row_t DIRECTED [26] = '{
    '{8'h00, 1'b1, 1'b1, '{1'b0, tgrcc_pkg::ERR_NO_SEP, 16'h0000, 16'h0000}},
    '{8'h26, 1'b0, 1'b0, '0},
    '{8'h26, 1'b0, 1'b0, '0},
    '{8'h46, 1'b0, 1'b0, '0},
    '{8'h46, 1'b0, 1'b0, '0},
    '{8'h62, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, '0},
    '{8'h7e, 1'b1, 1'b1, '{1'b1, tgrcc_pkg::ERR_OK, 16'h004c, 16'hffb4}},
    '{8'h26, 1'b0, 1'b0, '0},
    '{8'h26, 1'b0, 1'b0, '0},
    '{8'h31, 1'b0, 1'b0, '0},
    '{8'h32, 1'b0, 1'b0, '0},
    '{8'h33, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, '0},
    '{8'h26, 1'b1, 1'b1, '{1'b0, tgrcc_pkg::ERR_CHECKSUM, 16'h004c, 16'h1234}},
    '{8'h26, 1'b0, 1'b0, '0},
    '{8'h26, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h26, 1'b0, 1'b0, '0},
    '{8'h26, 1'b0, 1'b0, '0},
    '{8'h39, 1'b0, 1'b0, '0},
    '{8'h67, 1'b0, 1'b0, '0},
    '{8'h31, 1'b0, 1'b0, '0},
    '{8'h32, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b1, 1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  tgrcc_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  tgrcc_pkg::out_item_t out_data;

  tgrcc_pkg::out_item_t verdicts_due[$];
  int        mismatches = 0;
  int        bytes_counted = 0;
  bit        calm = 1'b0;

  logic [15:0] gauge_sum;
  logic [15:0] gauge_sep_sum;
  logic [15:0] gauge_hex;
  logic        gauge_prev_amp;
  logic        gauge_sep_seen;
  logic        gauge_hex_stop;
  logic        gauge_ended;
  logic [2:0]  gauge_tail;

  tank_gauge_reply_checksum_checker u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 34);
  end

  function automatic bit decode_hex(input logic [7:0] c, output logic [3:0] d);
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c[3:0];
      return 1'b1;
    end
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d = 4'(c[2:0] + 4'd9);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_glyph(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + n;
    return (lower ? 8'h61 : 8'h41) + (n - 4'd10);
  endfunction

  task automatic gauge_clear();
    gauge_sum      = '0;
    gauge_sep_sum  = '0;
    gauge_hex      = '0;
    gauge_prev_amp = 1'b0;
    gauge_sep_seen = 1'b0;
    gauge_hex_stop = 1'b0;
    gauge_ended    = 1'b0;
    gauge_tail     = '0;
  endtask

  task automatic gauge_absorb(input tgrcc_pkg::in_item_t item, output bit has_verdict,
                              output tgrcc_pkg::out_item_t verdict);
    logic [3:0] nib;
    has_verdict = 1'b0;
    verdict = '0;
    if (!gauge_ended) begin
      if (item.reply_byte == 8'h00) begin
        gauge_ended = 1'b1;
      end else if (!gauge_sep_seen) begin
        gauge_sum = gauge_sum + item.reply_byte;
        if (item.reply_byte == tgrcc_pkg::SEP_CHAR && gauge_prev_amp) begin
          gauge_sep_seen = 1'b1;
          gauge_sep_sum  = gauge_sum;
        end
        gauge_prev_amp = (item.reply_byte == tgrcc_pkg::SEP_CHAR);
      end else begin
        if (gauge_tail < tgrcc_pkg::HEX_LEN && !gauge_hex_stop) begin
          if (decode_hex(item.reply_byte, nib)) gauge_hex = {gauge_hex[11:0], nib};
          else gauge_hex_stop = 1'b1;
        end
        if (gauge_tail < tgrcc_pkg::TAIL_SAT) gauge_tail++;
      end
    end
    if (item.last_byte) begin
      has_verdict = 1'b1;
      if (!gauge_sep_seen) begin
        verdict.error_code = tgrcc_pkg::ERR_NO_SEP;
      end else begin
        verdict.computed_sum      = gauge_sep_sum;
        verdict.received_checksum = gauge_hex;
        if (gauge_tail != tgrcc_pkg::TAIL_LEN) verdict.error_code = tgrcc_pkg::ERR_TAIL_LEN;
        else if ({1'b0, gauge_sep_sum} + {1'b0, gauge_hex} != tgrcc_pkg::CHECK_TOTAL)
          verdict.error_code = tgrcc_pkg::ERR_CHECKSUM;
        else verdict.error_code = tgrcc_pkg::ERR_OK;
      end
      verdict.check_passed = (verdict.error_code == tgrcc_pkg::ERR_OK);
      gauge_clear();
    end
  endtask

  task automatic offer_byte(input tgrcc_pkg::in_item_t item, input bit pinned,
                            input tgrcc_pkg::out_item_t want);
    bit                   taken;
    bit                   has_v;
    tgrcc_pkg::out_item_t v;
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    if (!gauge_ended || item.last_byte) bytes_counted++;
    gauge_absorb(item, has_v, v);
    if (has_v) verdicts_due.push_back(pinned ? want : v);
  endtask

  task automatic drain_verdicts(input int limit);
    int n;
    in_valid <= 1'b0;
    for (n = 0; n < limit && verdicts_due.size() != 0; n++) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [15:0] exp,
                              input logic [15:0] act);
    if (exp !== act) begin
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin : result_monitor
    tgrcc_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        report_field("check_passed", 16'(want.check_passed), 16'(out_data.check_passed));
        report_field("error_code", 16'(want.error_code), 16'(out_data.error_code));
        report_field("computed_sum", want.computed_sum, out_data.computed_sum);
        report_field("received_checksum", want.received_checksum,
                     out_data.received_checksum);
      end
    end
  end

  initial begin : stimulus
    tgrcc_pkg::in_item_t item;
    logic [7:0]  reply_q[$];
    logic [7:0]  b;
    logic [15:0] sum16;
    logic [15:0] code;
    int          kind;
    int          plen;
    int          tlen;
    int          replies;
    gauge_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      item = '{reply_byte: DIRECTED[i].b, last_byte: DIRECTED[i].lst};
      offer_byte(item, DIRECTED[i].pinned, DIRECTED[i].want);
    end
    drain_verdicts(10000);

    replies = 0;
    while (bytes_counted < ITEM_TARGET) begin
      calm = (replies >= 30 && replies < 55);
      kind = $urandom_range(99);
      reply_q.delete();
      sum16 = '0;
      if (kind < 85) begin
        // Prefix without ampersands so the separator lands where it is placed.
        if ($urandom_range(29) == 0) plen = $urandom_range(320, 290);
        else plen = $urandom_range(12);
        for (int i = 0; i < plen; i++) begin
          b = (plen > 100) ? 8'($urandom_range(255, 200)) : 8'($urandom_range(255, 1));
          if (b == tgrcc_pkg::SEP_CHAR) b = 8'h25;
          reply_q.push_back(b);
          sum16 = sum16 + b;
        end
        reply_q.push_back(tgrcc_pkg::SEP_CHAR);
        reply_q.push_back(tgrcc_pkg::SEP_CHAR);
        sum16 = sum16 + 16'h004c;
      end
      if (kind < 70) begin
        code = (kind < 45) ? 16'(17'h10000 - {1'b0, sum16}) : 16'($urandom);
        for (int i = 3; i >= 0; i--)
          reply_q.push_back(hex_glyph(code[4*i +: 4], 1'($urandom_range(1))));
        reply_q.push_back(8'($urandom_range(255, 1)));
      end else if (kind < 85) begin
        tlen = $urandom_range(9);
        for (int i = 0; i < tlen; i++) begin
          if ($urandom_range(14) == 0) b = 8'h00;
          else if ($urandom_range(1) != 0)
            b = hex_glyph(4'($urandom), 1'($urandom_range(1)));
          else b = 8'($urandom_range(255));
          reply_q.push_back(b);
        end
        if (reply_q.size() == 0) reply_q.push_back(8'($urandom_range(255)));
      end else begin
        plen = $urandom_range(12, 1);
        for (int i = 0; i < plen; i++)
          reply_q.push_back(($urandom_range(3) == 0) ? tgrcc_pkg::SEP_CHAR
                                                     : 8'($urandom_range(255)));
      end

      foreach (reply_q[i]) begin
        item = '{reply_byte: reply_q[i], last_byte: (i == reply_q.size() - 1)};
        offer_byte(item, 1'b0, '0);
      end
      replies++;
      if (replies % 25 == 0) drain_verdicts(10000);
    end

    calm = 1'b0;
    drain_verdicts(10000);
    repeat (4) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      $display("%0t: expected %0d more results, actual 0", $time, verdicts_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
